// ===== sv/electrode_compensation_fir_macros.svh =====
// Assertion macros for the electrode compensation FIR block.
// Used by the port-level checker; expects clk and rst_n in scope.
`ifndef ELECTRODE_COMPENSATION_FIR_MACROS_SVH
`define ELECTRODE_COMPENSATION_FIR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ECF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ECF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ecf_pkg.sv =====
// Shared constants, codes and types for the electrode compensation FIR.
// No dependencies; imported by every module of the block.
package ecf_pkg;

  localparam int MAX_TAPS = 64;
  localparam int TAP_AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  localparam int CFG_W  = 7;
  localparam int CMD_W  = 2;
  localparam int TIDX_W = 6;
  localparam int TAP_W  = 32;
  localparam int CUR_W  = 16;
  localparam int VOLT_W = 32;

  localparam int PROD_W = CUR_W + TAP_W;
  localparam int ACC_W  = PROD_W + TAP_AW;

  // divide by 1e6 = 2^6 * 15625: drop 6 bits, then multiply by a rounded-up
  // reciprocal of 15625 and keep the bits above RCP_SHIFT (exact for the
  // magnitudes the accumulator can reach)
  localparam int DIV_PRE   = 6;
  localparam int X_W       = ACC_W - DIV_PRE;
  localparam int RCP_W     = 48;
  localparam logic [RCP_W-1:0] RCP_M = 48'd147573952589677;
  localparam int RCP_SHIFT = 61;
  localparam int HALF_W    = 24;  // partial product operand width
  localparam int DIV_STEPS = 4;   // one HALF_W x HALF_W partial product per step
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int MUL_W     = X_W + RCP_W;
  localparam int Q_W       = MUL_W - RCP_SHIFT;
  localparam int DIFF_W    = Q_W + 2;

  localparam int DRAIN_CYCLES = 2;
  localparam int CNT_W = (TAP_AW > $clog2(DIV_STEPS)) ? TAP_AW : $clog2(DIV_STEPS);

  localparam logic signed [VOLT_W-1:0] OUT_MAX = {1'b0, {(VOLT_W-1){1'b1}}};
  localparam logic signed [VOLT_W-1:0] OUT_MIN = {1'b1, {(VOLT_W-1){1'b0}}};

  localparam logic [CMD_W-1:0] CMD_LOAD_TAP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROCESS  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_MAC,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } ecf_state_t;

  typedef struct packed {
    logic              load_tap;
    logic              clr_hist;
    logic              capture;
    logic              push;
    logic              issue;
    logic [TAP_AW-1:0] tap_addr;
    logic              div_load;
    logic              div_step;
    logic              finish;
  } ecf_cmd_t;

  typedef struct packed {
    logic [TAP_AW-1:0] len_m1;
    logic              out_busy;
  } ecf_sts_t;

endpackage

// ===== sv/electrode_compensation_fir.sv =====
// Electrode compensation FIR. A load transaction (command 0) writes one
// kernel tap in ohms and a clear transaction (command 2) empties the current
// history; both finish in the cycle they are taken, so they stream at one per
// clock. A process transaction (command 1) pushes current_pa into the history
// ring, convolves the last L currents with taps 0..L-1 (newest on tap 0),
// divides the sum by 1e6 toward zero and returns voltage_uv minus that value,
// clipped to 32 bits with out_saturated set on clipping. L is taps_in_use,
// written through cfg_wr_en/cfg_wr_data (0 reads as 1, above 64 as 64); a
// write also empties the history. Command 3 is dropped. After a process
// transaction is accepted, in_ready stays low through a push, the single
// multiply-accumulate unit over L taps (one tap per cycle from the tap and
// history memories), the pipeline drain, and the divide by 1e6: load,
// four 24x24 partial products of a reciprocal multiply, and result.
// The result sits in an output register, so the next transaction is taken
// while it waits for out_ready. Reset leaves all taps and history at zero.

// Top level; instantiates ecf_ctrl and ecf_datapath, uses ecf_pkg.
module electrode_compensation_fir (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ecf_pkg::CMD_W-1:0]         in_command,
  input  logic [ecf_pkg::TIDX_W-1:0]        in_tap_index,
  input  logic signed [ecf_pkg::TAP_W-1:0]  in_tap_value,
  input  logic signed [ecf_pkg::CUR_W-1:0]  in_current_pa,
  input  logic signed [ecf_pkg::VOLT_W-1:0] in_voltage_uv,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ecf_pkg::VOLT_W-1:0] out_compensated_uv,
  output logic                              out_saturated,
  // taps_in_use register
  input  logic                              cfg_wr_en,
  input  logic [ecf_pkg::CFG_W-1:0]         cfg_wr_data
);
  import ecf_pkg::*;

  ecf_cmd_t cmd;  // sequencer -> datapath
  ecf_sts_t sts;  // datapath -> sequencer

  ecf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ecf_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_tap_index       (in_tap_index),
    .in_tap_value       (in_tap_value),
    .in_current_pa      (in_current_pa),
    .in_voltage_uv      (in_voltage_uv),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_compensated_uv (out_compensated_uv),
    .out_saturated      (out_saturated)
  );

endmodule

// ===== sv/ecf_ctrl.sv =====
// Sequencer for the electrode compensation FIR.
// Depends on ecf_pkg; drives ecf_datapath through ecf_cmd_t.
module ecf_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [ecf_pkg::CMD_W-1:0] in_command,
  output logic                    in_ready,
  input  ecf_pkg::ecf_sts_t       sts,
  output ecf_pkg::ecf_cmd_t       cmd
);
  import ecf_pkg::*;

  ecf_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_PROCESS)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_nxt = ST_MAC;
        cnt_nxt   = '0;
      end
      ST_MAC: begin
        if (cnt_r[TAP_AW-1:0] == sts.len_m1) begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (cnt_r == CNT_W'(DRAIN_CYCLES - 1)) begin
          state_nxt = ST_DIV_LOAD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DIV_LOAD: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    cmd.load_tap = accept && (in_command == CMD_LOAD_TAP);
    cmd.clr_hist = accept && (in_command == CMD_CLEAR);
    cmd.capture  = accept && (in_command == CMD_PROCESS);
    cmd.push     = (state_r == ST_PUSH);
    cmd.issue    = (state_r == ST_MAC);
    cmd.tap_addr = cnt_r[TAP_AW-1:0];
    cmd.div_load = (state_r == ST_DIV_LOAD);
    cmd.div_step = (state_r == ST_DIV);
    cmd.finish   = (state_r == ST_DONE) && !sts.out_busy;
  end

endmodule

// ===== sv/ecf_datapath.sv =====
// Datapath of the electrode compensation FIR: tap and history memories,
// MAC pipeline, divide-by-1e6 unit and output register. Depends on ecf_pkg.
module ecf_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ecf_pkg::ecf_cmd_t                 cmd,
  output ecf_pkg::ecf_sts_t                 sts,
  input  logic [ecf_pkg::TIDX_W-1:0]        in_tap_index,
  input  logic signed [ecf_pkg::TAP_W-1:0]  in_tap_value,
  input  logic signed [ecf_pkg::CUR_W-1:0]  in_current_pa,
  input  logic signed [ecf_pkg::VOLT_W-1:0] in_voltage_uv,
  input  logic                              cfg_wr_en,
  input  logic [ecf_pkg::CFG_W-1:0]         cfg_wr_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ecf_pkg::VOLT_W-1:0] out_compensated_uv,
  output logic                              out_saturated
);
  import ecf_pkg::*;

  // memories
  logic signed [TAP_W-1:0] kern_mem [MAX_TAPS];
  logic signed [CUR_W-1:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]     kvalid_r;
  logic [MAX_TAPS-1:0]     hvalid_r;

  logic [TAP_AW-1:0] len_m1_r, cfg_len_m1;
  logic [TAP_AW-1:0] wp_r;
  logic [TAP_AW-1:0] hist_ptr_r;
  logic [TAP_AW-1:0] load_addr;
  logic              load_ok;

  logic signed [CUR_W-1:0]  cur_r;
  logic signed [VOLT_W-1:0] volt_r;

  logic signed [TAP_W-1:0] kern_rd_r, kern_eff;
  logic signed [CUR_W-1:0] hist_rd_r, hist_eff;
  logic                    kvld_rd_r, hvld_rd_r;
  logic                    rd_vld_r, prod_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]         acc_mag;

  logic [X_W-1:0]      mul_x_r;
  logic [MUL_W-1:0]    mul_acc_r, mul_term;
  logic [STEP_W-1:0]   mul_sel_r;
  logic [HALF_W-1:0]   mul_a, mul_b;
  logic [2*HALF_W-1:0] mul_pp;
  logic                neg_r;
  logic [Q_W-1:0]      q_mag;

  logic signed [DIFF_W-1:0] q_sgn, diff_v;
  logic signed [VOLT_W-1:0] res_v;
  logic                     sat_v;

  logic out_valid_r, out_sat_r;
  logic signed [VOLT_W-1:0] out_val_r;

  // tap count clamp: 0 -> 1 tap, above MAX_TAPS -> MAX_TAPS
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_len_m1 = '0;
    end else if (int'(cfg_wr_data) > MAX_TAPS) begin
      cfg_len_m1 = TAP_AW'(MAX_TAPS - 1);
    end else begin
      cfg_len_m1 = TAP_AW'(cfg_wr_data - CFG_W'(1));
    end
  end

  assign load_ok   = int'(in_tap_index) < MAX_TAPS;
  assign load_addr = TAP_AW'(in_tap_index);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_m1_r    <= '0;
      wp_r        <= '0;
      kvalid_r    <= '0;
      hvalid_r    <= '0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.issue;
      prod_vld_r <= rd_vld_r;
      if (cmd.load_tap && load_ok) begin
        kvalid_r[load_addr] <= 1'b1;
      end
      if (cfg_wr_en) begin
        len_m1_r <= cfg_len_m1;
        wp_r     <= '0;
        hvalid_r <= '0;
      end else if (cmd.clr_hist) begin
        wp_r     <= '0;
        hvalid_r <= '0;
      end else if (cmd.push) begin
        hvalid_r[wp_r] <= 1'b1;
        wp_r <= (wp_r == len_m1_r) ? '0 : wp_r + TAP_AW'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memories, read registers
  always_ff @(posedge clk) begin
    if (cmd.load_tap && load_ok) begin
      kern_mem[load_addr] <= in_tap_value;
    end
    if (cmd.push) begin
      hist_mem[wp_r] <= cur_r;
    end
    if (cmd.issue) begin
      kern_rd_r <= kern_mem[cmd.tap_addr];
      hist_rd_r <= hist_mem[hist_ptr_r];
      kvld_rd_r <= kvalid_r[cmd.tap_addr];
      hvld_rd_r <= hvalid_r[hist_ptr_r];
    end
  end

  assign kern_eff = kvld_rd_r ? kern_rd_r : '0;
  assign hist_eff = hvld_rd_r ? hist_rd_r : '0;
  assign acc_mag  = acc_r[ACC_W-1] ? (~acc_r + ACC_W'(1)) : acc_r;

  // reciprocal multiply, one partial product per step:
  // lo*lo, x_lo*m_hi, x_hi*m_lo, hi*hi
  always_comb begin
    mul_a  = mul_sel_r[1] ? mul_x_r[X_W-1:HALF_W] : mul_x_r[HALF_W-1:0];
    mul_b  = mul_sel_r[0] ? RCP_M[RCP_W-1:HALF_W] : RCP_M[HALF_W-1:0];
    mul_pp = mul_a * mul_b;
    case (mul_sel_r)
      STEP_W'(0): mul_term = MUL_W'(mul_pp);
      STEP_W'(3): mul_term = MUL_W'(mul_pp) << (2 * HALF_W);
      default:    mul_term = MUL_W'(mul_pp) << HALF_W;
    endcase
  end

  assign q_mag = mul_acc_r[MUL_W-1:RCP_SHIFT];

  // final subtract and saturate
  always_comb begin
    q_sgn = $signed({2'b00, q_mag});
    if (neg_r) begin
      q_sgn = -q_sgn;
    end
    diff_v = DIFF_W'(volt_r) - q_sgn;
    if (diff_v > DIFF_W'(OUT_MAX)) begin
      res_v = OUT_MAX;
      sat_v = 1'b1;
    end else if (diff_v < DIFF_W'(OUT_MIN)) begin
      res_v = OUT_MIN;
      sat_v = 1'b1;
    end else begin
      res_v = diff_v[VOLT_W-1:0];
      sat_v = 1'b0;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r  <= in_current_pa;
      volt_r <= in_voltage_uv;
    end
    if (cmd.push) begin
      hist_ptr_r <= wp_r;
    end else if (cmd.issue) begin
      hist_ptr_r <= (hist_ptr_r == '0) ? len_m1_r : hist_ptr_r - TAP_AW'(1);
    end
    prod_r <= PROD_W'(hist_eff) * PROD_W'(kern_eff);
    if (cmd.push) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.div_load) begin
      neg_r     <= acc_r[ACC_W-1];
      mul_x_r   <= acc_mag[ACC_W-1:DIV_PRE];
      mul_acc_r <= '0;
      mul_sel_r <= '0;
    end else if (cmd.div_step) begin
      mul_acc_r <= mul_acc_r + mul_term;
      mul_sel_r <= mul_sel_r + STEP_W'(1);
    end
    if (cmd.finish) begin
      out_val_r <= res_v;
      out_sat_r <= sat_v;
    end
  end

  assign sts.len_m1   = len_m1_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid          = out_valid_r;
  assign out_compensated_uv = out_val_r;
  assign out_saturated      = out_sat_r;

endmodule

// ===== sv/ecf_checker.sv =====
// Port-level checks for the electrode compensation FIR, bound to the top.
// Depends on ecf_pkg and electrode_compensation_fir_macros.svh.
`include "electrode_compensation_fir_macros.svh"

module ecf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [ecf_pkg::CMD_W-1:0]         in_command,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ecf_pkg::VOLT_W-1:0] out_compensated_uv,
  input logic                              out_saturated
);
  import ecf_pkg::*;

  // clipping flag only with a rail value
  `ECF_ASSERT_IMP(a_sat_rail, out_valid && out_saturated, (out_compensated_uv == OUT_MAX) || (out_compensated_uv == OUT_MIN), "saturated result not at a rail")

  // a process transaction occupies the block
  `ECF_ASSERT_NXT(a_proc_busy, in_valid && in_ready && (in_command == CMD_PROCESS), !in_ready, "ready after process transaction")

  // load, clear and unused commands complete at once
  `ECF_ASSERT_NXT(a_cmd_fast, in_valid && in_ready && (in_command != CMD_PROCESS), in_ready, "ready dropped after non-process transaction")

  // a stalled result holds
  `ECF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_compensated_uv) && $stable(out_saturated), "stalled result changed")

endmodule

bind electrode_compensation_fir ecf_checker u_ecf_checker (.*);
